@@ rtl/core/tti_pkg.sv @@
// ----------------------------------------------------------------------------
// tti_pkg
// Shared constants and types for the thermistor table interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

    // Default sizes
    localparam int DEPTH_DEF       = 256;
    localparam int VALUE_WIDTH_DEF = 20;

    // Fixed field widths
    localparam int INDEX_W  = 8;
    localparam int OFFSET_W = 11;
    localparam int TEMP_W   = 13;
    localparam int STATUS_W = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Arithmetic constants
    localparam int STEP_DEG     = 10;
    localparam int LAST_RESET   = 160;
    localparam int OFFSET_RESET = -400;
    localparam int TEMP_MIN     = -4096;
    localparam int TEMP_MAX     = 4095;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OPEN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Register index codes (paddr bit 2)
    localparam logic REG_LAST_INDEX  = 1'b0;
    localparam logic REG_TEMP_OFFSET = 1'b1;

    // Divider status back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_stat;

endpackage

@@ rtl/core/thermistor_table_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_top
// NTC table lookup: binary search over a falling table, then linear
// interpolation to tenths of a degree with floor division.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one transaction per item. With
//   i_func = write, i_entry_value is stored at i_entry_index (ignored past the
//   table end); it gives no result and does not stall the input. With
//   i_func = query, i_reading is converted and one result (o_temperature,
//   o_status) appears on the output channel (o_valid / i_stall).
//   A query takes k search steps, k at most ceil(log2(n)), n = last_index;
//   equal neighbors skip the divider and return sooner. Open and short
//   faults are reported from the two end checks, without a search. Each
//   search step waits on a registered table read, and the serial divider
//   produces one quotient bit per cycle; o_stall stays high for the whole
//   query and drops once the sequencer is idle again, when the next
//   transaction can be taken. Items are processed one at a time.
//   A finished result sits in an output register; a stalled receiver holds
//   it there. The next transaction is still taken, and a further finished
//   result waits in the sequencer until the output register is free.
//   Reset clears the sequencer and output valid, and loads last_index = 160
//   and temp_offset = -400. Table contents are undefined until written.
//   Registers (APB, pready tied high): 0x0 last_index, 0x4 temp_offset.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_top #(
    parameter int TABLE_DEPTH = tti_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = tti_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic [tti_pkg::INDEX_W-1:0]       i_entry_index,
    input  logic [VALUE_WIDTH-1:0]            i_entry_value,
    input  logic [VALUE_WIDTH-1:0]            i_reading,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [tti_pkg::TEMP_W-1:0] o_temperature,
    output logic [tti_pkg::STATUS_W-1:0]      o_status,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tti_pkg::PADDR_W-1:0]       paddr,
    input  logic [tti_pkg::PDATA_W-1:0]       pwdata,
    output logic [tti_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import tti_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int VW = VALUE_WIDTH;
    localparam int NW = VW + 4;          // |10 * difference| magnitude
    localparam int QW = NW + 1;          // signed quotient
    localparam int SW = NW + 16;         // temperature sum before clamp
    localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK0  = 4'd1;
    localparam logic [3:0] S_CHKN  = 4'd2;
    localparam logic [3:0] S_ISSUE = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_GTOP  = 4'd5;
    localparam logic [3:0] S_GBOT  = 4'd6;
    localparam logic [3:0] S_PREP  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0]         r_last;
    logic signed [OFFSET_W-1:0] r_offset;
    logic                       cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= INDEX_W'(LAST_RESET);
            r_offset <= OFFSET_W'(OFFSET_RESET);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LAST_INDEX:  r_last   <= pwdata[INDEX_W-1:0];
                REG_TEMP_OFFSET: r_offset <= $signed(pwdata[OFFSET_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LAST_INDEX:  prdata = {{(PDATA_W-INDEX_W){1'b0}}, r_last};
            REG_TEMP_OFFSET: prdata = {{(PDATA_W-OFFSET_W){1'b0}}, r_offset};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]                r_state,     n_state;
    logic [VW-1:0]             r_v,         n_v;
    logic [AW-1:0]             r_bot,       n_bot;
    logic [AW-1:0]             r_top,       n_top;
    logic [VW-1:0]             r_vtop,      n_vtop;
    logic signed [VW:0]        r_diff,      n_diff;
    logic signed [VW:0]        r_den,       n_den;
    logic                      r_neg,       n_neg;
    logic signed [QW-1:0]      r_q,         n_q;
    logic signed [TEMP_W-1:0]  r_res_temp,  n_res_temp;
    logic [STATUS_W-1:0]       r_res_stat,  n_res_stat;
    logic                      r_out_valid;
    logic signed [TEMP_W-1:0]  r_out_temp;
    logic [STATUS_W-1:0]       r_out_stat;

    // ------------------------------------------------------------------
    // Table and divider
    // ------------------------------------------------------------------
    logic                in_acc;
    logic [IW-1:0]       idx_ext;
    logic                tbl_wr;
    logic [AW-1:0]       rd_addr;
    logic [VW-1:0]       rd_data;

    logic                div_start;
    logic [NW-1:0]       div_num;
    logic [VW-1:0]       div_den;
    logic [NW-1:0]       div_quot;
    t_div_stat           div_stat;

    assign in_acc  = i_valid && !o_stall;
    assign idx_ext = IW'(i_entry_index);
    assign tbl_wr  = in_acc && (i_func == FUNC_WRITE) && (idx_ext <= IW'(TABLE_DEPTH - 1));

    tti_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr),
        .i_wr_addr (idx_ext[AW-1:0]),
        .i_wr_data (i_entry_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tti_divider #(
        .NUM_W (NW),
        .DEN_W (VW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [IW-1:0]        last_ext;
    logic [AW-1:0]        last_n;
    logic [AW:0]          mid_sum;
    logic [AW-1:0]        mid;
    logic                 last_step;
    logic [VW-1:0]        diff_mag;
    logic [VW-1:0]        den_mag;
    logic signed [QW-1:0] q_pos;
    logic signed [QW-1:0] q_fin;
    logic signed [SW-1:0] t_sum;
    logic signed [SW-1:0] t_sat;
    logic                 out_free;

    always_comb begin
        // Clamp last_index into 1 .. TABLE_DEPTH-1
        last_ext = IW'(r_last);
        if (last_ext == '0) begin
            last_ext = IW'(1);
        end
        if (last_ext > IW'(TABLE_DEPTH - 1)) begin
            last_ext = IW'(TABLE_DEPTH - 1);
        end
        last_n = last_ext[AW-1:0];

        mid_sum   = {1'b0, r_bot} + {1'b0, r_top};
        mid       = mid_sum[AW:1];
        last_step = (r_top - r_bot) == AW'(1);

        diff_mag = r_diff[VW] ? VW'(-r_diff) : r_diff[VW-1:0];
        den_mag  = r_den[VW]  ? VW'(-r_den)  : r_den[VW-1:0];

        // Floor the signed quotient: round toward minus infinity on mixed signs
        q_pos = $signed({1'b0, div_quot});
        q_fin = r_neg ? (-q_pos - $signed({{(QW-1){1'b0}}, div_stat.rem_nz})) : q_pos;

        // bot*10 + floor(10*(vbot-v)/(vbot-vtop)) + offset
        t_sum = $signed(SW'(r_bot) * SW'(STEP_DEG)) + SW'(r_q) + SW'(r_offset);
        t_sat = t_sum;
        if (t_sum < SW'(TEMP_MIN)) begin
            t_sat = SW'(TEMP_MIN);
        end
        if (t_sum > SW'(TEMP_MAX)) begin
            t_sat = SW'(TEMP_MAX);
        end

        out_free = !r_out_valid || !i_stall;
    end

    assign div_num = NW'(diff_mag) * NW'(STEP_DEG);
    assign div_den = den_mag;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_v        = r_v;
        n_bot      = r_bot;
        n_top      = r_top;
        n_vtop     = r_vtop;
        n_diff     = r_diff;
        n_den      = r_den;
        n_neg      = r_neg;
        n_q        = r_q;
        n_res_temp = r_res_temp;
        n_res_stat = r_res_stat;
        rd_addr    = '0;
        div_start  = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Entry zero is fetched at the accept edge
                rd_addr = '0;
                if (in_acc && (i_func == FUNC_QUERY)) begin
                    n_v     = i_reading;
                    n_state = S_CHK0;
                end
            end
            S_CHK0: begin
                rd_addr = last_n;
                if (r_v > rd_data) begin
                    n_res_temp = '0;
                    n_res_stat = ST_OPEN;
                    n_state    = S_FIN;
                end else begin
                    n_state = S_CHKN;
                end
            end
            S_CHKN: begin
                if (r_v < rd_data) begin
                    n_res_temp = '0;
                    n_res_stat = ST_SHORT;
                    n_state    = S_FIN;
                end else begin
                    n_bot   = '0;
                    n_top   = last_n;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (last_step) begin
                    rd_addr = r_top;
                    n_state = S_GTOP;
                end else begin
                    rd_addr = mid;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_v < rd_data) begin
                    n_bot = mid;
                end else begin
                    n_top = mid;
                end
                n_state = S_ISSUE;
            end
            S_GTOP: begin
                n_vtop  = rd_data;
                rd_addr = r_bot;
                n_state = S_GBOT;
            end
            S_GBOT: begin
                n_diff  = $signed({1'b0, rd_data}) - $signed({1'b0, r_v});
                n_den   = $signed({1'b0, rd_data}) - $signed({1'b0, r_vtop});
                n_state = S_PREP;
            end
            S_PREP: begin
                if (r_den == '0) begin
                    // Equal neighbours: no slope, report the bottom degree
                    n_q     = '0;
                    n_state = S_SUM;
                end else begin
                    div_start = 1'b1;
                    n_neg     = r_diff[VW] ^ r_den[VW];
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_q     = q_fin;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_res_temp = t_sat[TEMP_W-1:0];
                n_res_stat = ST_OK;
                n_state    = S_FIN;
            end
            S_FIN: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_bot      <= n_bot;
        r_top      <= n_top;
        r_vtop     <= n_vtop;
        r_diff     <= n_diff;
        r_den      <= n_den;
        r_neg      <= n_neg;
        r_q        <= n_q;
        r_res_temp <= n_res_temp;
        r_res_stat <= n_res_stat;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out_temp <= r_res_temp;
            r_out_stat <= r_res_stat;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_temperature = r_out_temp;
    assign o_status      = r_out_stat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fault_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_temperature == '0))
        else $error("fault result carries a nonzero temperature");

    a_search_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ISSUE) || (r_state == S_CMP)) |-> (r_bot < r_top))
        else $error("search bounds crossed");

    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_func == FUNC_QUERY)) |=> o_stall)
        else $error("query accepted without entering the sequencer");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

endmodule

@@ rtl/core/tti_table.sv @@
// ----------------------------------------------------------------------------
// tti_table
// Single-port-write, single-port-read table memory with registered read data.
// ----------------------------------------------------------------------------
module tti_table #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/tti_divider.sv @@
// ----------------------------------------------------------------------------
// tti_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tti_divider #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [NUM_W-1:0]         i_num,
    input  logic [DEN_W-1:0]         i_den,
    output logic [NUM_W-1:0]         o_quot,
    output tti_pkg::t_div_stat       o_stat
);
    import tti_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_done;

    logic [DEN_W:0]   rem_shift;
    logic             fits;
    logic [DEN_W:0]   rem_next;

    always_comb begin
        rem_shift = {r_rem, r_quo[NUM_W-1]};
        fits      = rem_shift >= {1'b0, r_den};
        rem_next  = fits ? (rem_shift - {1'b0, r_den}) : rem_shift;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(NUM_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Datapath: shift the numerator out, the quotient in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= rem_next[DEN_W-1:0];
        end
    end

    assign o_quot        = r_quo;
    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = |r_rem;

endmodule
